// ----- hw/rtl/vm_instruction_execute_unit_top_assert.svh -----
// Assertion macros shared by the instruction execute unit RTL.
`ifndef VM_INSTRUCTION_EXECUTE_UNIT_TOP_ASSERT_SVH
`define VM_INSTRUCTION_EXECUTE_UNIT_TOP_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define VMXU_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define VMXU_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- hw/rtl/vmxu_pkg.sv -----
// Types and constants of the instruction execute unit.
`default_nettype none
package vmxu_pkg;

  typedef enum logic [1:0] {
    ACT_WRITE = 2'd0,
    ACT_EXEC  = 2'd1,
    ACT_READ  = 2'd2,
    ACT_PIXEL = 2'd3
  } action_e;

  typedef enum logic [2:0] {
    EV_NONE  = 3'd0,
    EV_CLEAR = 3'd1,
    EV_DRAW  = 3'd2,
    EV_WAIT  = 3'd3,
    EV_STACK = 3'd4
  } event_e;

  typedef enum logic [3:0] {
    OP_SYS  = 4'h0, OP_JP   = 4'h1, OP_CALL = 4'h2, OP_SEI  = 4'h3,
    OP_SNEI = 4'h4, OP_SER  = 4'h5, OP_LDI  = 4'h6, OP_ADDI = 4'h7,
    OP_ALU  = 4'h8, OP_SNER = 4'h9, OP_LDIX = 4'hA, OP_JPV0 = 4'hB,
    OP_RND  = 4'hC, OP_DRW  = 4'hD, OP_KEY  = 4'hE, OP_MISC = 4'hF
  } opcode_e;

  typedef enum logic [4:0] {
    S_IDLE, S_RRAM, S_RPIX, S_F1, S_F2, S_F3, S_X, S_RET, S_WF,
    S_DRD, S_DWR, S_DVF, S_BCD, S_STR, S_STW, S_LDR, S_LDW, S_DONE
  } state_e;

  localparam logic [15:0] W_CLS   = 16'h00E0;
  localparam logic [15:0] W_RET   = 16'h00EE;
  localparam logic [7:0]  NN_SKP  = 8'h9E;
  localparam logic [7:0]  NN_SKNP = 8'hA1;

  localparam logic [3:0] ALU_MOV = 4'h0;
  localparam logic [3:0] ALU_OR  = 4'h1;
  localparam logic [3:0] ALU_AND = 4'h2;
  localparam logic [3:0] ALU_XOR = 4'h3;
  localparam logic [3:0] ALU_ADD = 4'h4;
  localparam logic [3:0] ALU_SUB = 4'h5;
  localparam logic [3:0] ALU_SHR = 4'h6;
  localparam logic [3:0] ALU_SBN = 4'h7;
  localparam logic [3:0] ALU_SHL = 4'hE;

  localparam logic [7:0] F_GDT  = 8'h07;
  localparam logic [7:0] F_WAIT = 8'h0A;
  localparam logic [7:0] F_SDT  = 8'h15;
  localparam logic [7:0] F_SST  = 8'h18;
  localparam logic [7:0] F_ADDI = 8'h1E;
  localparam logic [7:0] F_FONT = 8'h29;
  localparam logic [7:0] F_BCD  = 8'h33;
  localparam logic [7:0] F_STOR = 8'h55;
  localparam logic [7:0] F_LOAD = 8'h65;

  localparam logic [3:0]  VF_IDX   = 4'hF;
  localparam logic [11:0] PC_RESET = 12'd512;

  typedef struct packed {
    action_e     action;
    logic [11:0] address;
    logic [7:0]  write_data;
    logic [15:0] key_state;
    logic [7:0]  random_byte;
  } in_item_t;

  typedef struct packed {
    event_e      event_res;
    logic [11:0] next_pc;
    logic [15:0] executed_word;
    logic [7:0]  read_data;
    logic [7:0]  carry_flag;
    logic [3:0]  wait_register;
  } out_item_t;

endpackage
`default_nettype wire

// ----- hw/rtl/vmxu_if.sv -----
// Valid/ready channel interfaces for the input items and the result items.
`default_nettype none
interface vmxu_in_if;
  import vmxu_pkg::*;
  logic     valid;
  logic     ready;
  in_item_t data;
  modport source(output valid, output data, input ready);
  modport sink(input valid, input data, output ready);
endinterface

interface vmxu_out_if;
  import vmxu_pkg::*;
  logic      valid;
  logic      ready;
  out_item_t data;
  modport source(output valid, output data, input ready);
  modport sink(input valid, input data, output ready);
endinterface
`default_nettype wire

// ----- hw/rtl/vm_instruction_execute_unit_top.sv -----
// Work steps through states: fetch in S_F1, S_F2, S_F3, execute in S_X; a draw visits
// S_DRD and S_DWR per sprite row, Fx55/Fx65 visit S_STR/S_STW or S_LDR/S_LDW per
// register and Fx33 writes its digits in S_BCD, visiting the memories in turn.
// One item is in work at a time; the next is taken once the result is registered.
// Reset clears the registers, stack level, timers and frame at once through per-row
// and per-register valid bits; RAM and the return stack are not cleared.
`default_nettype none
`include "vm_instruction_execute_unit_top_assert.svh"
module vm_instruction_execute_unit_top #(
  parameter int RAM_BYTES   = 4096,
  parameter int STACK_DEPTH = 16,
  parameter int SCREEN_W    = 64,
  parameter int SCREEN_H    = 32
) (
  input  wire         clk_i,
  input  wire         rst_ni,
  vmxu_in_if.sink     in_i,
  vmxu_out_if.source  out_o
);
  import vmxu_pkg::*;

  localparam int AW     = $clog2(RAM_BYTES);
  localparam int SW     = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;
  localparam int CW     = $clog2(SCREEN_W);
  localparam int HW     = $clog2(SCREEN_H);
  localparam int PIXELS = SCREEN_W * SCREEN_H;

  function automatic logic [AW-1:0] ram_at(input logic [12:0] a);
    ram_at = AW'(a % 13'(RAM_BYTES));
  endfunction

  state_e state_q, state_d;
  logic [11:0] pc_q, pc_d, i_q, i_d, addr_q;
  logic [4:0]  sl_q, sl_d;
  logic [7:0]  dt_q, dt_d, st_q, st_d, vf_q, vf_d;
  logic [15:0] vv_q, vv_d, word_q, word_d, keys_q;
  logic [SCREEN_H-1:0] rv_q, rv_d;
  logic [7:0]  vx_q, vx_d, vy_q, vy_d, rnd_q, rd_q, rd_d;
  logic [3:0]  cnt_q, cnt_d, wreg_q, wreg_d;
  logic        hit_q, hit_d;
  event_e      ev_q, ev_d;
  logic        out_valid_q, out_valid_d;
  out_item_t   out_q, out_d;

  // Program RAM.
  logic [7:0]    ram_mem [RAM_BYTES];
  logic          ram_we;
  logic [AW-1:0] ram_waddr, ram_raddr;
  logic [7:0]    ram_wdata, ram_rdata_q;

  // Register file V0..VF.
  logic [7:0] vr_mem [16];
  logic       vr_we, vr_rvld_q;
  logic [3:0] vr_waddr, vr_raddr;
  logic [7:0] vr_wdata, vr_rdata_q, vr_val;

  // Return stack.
  logic [11:0]   stk_mem [STACK_DEPTH];
  logic          stk_we;
  logic [SW-1:0] stk_waddr, stk_raddr;
  logic [11:0]   stk_wdata, stk_rdata_q;

  // Frame, one row per entry.
  logic [SCREEN_W-1:0] fb_mem [SCREEN_H];
  logic                fb_we, fb_rvld_q;
  logic [HW-1:0]       fb_waddr, fb_raddr, draw_row;
  logic [SCREEN_W-1:0] fb_wdata, fb_rdata_q, fb_old, spr_mask;

  logic        in_acc, out_free;
  opcode_e     op;
  logic [3:0]  wx, wn;
  logic [7:0]  nn;
  logic [11:0] nnn, pc_n, pc_s;
  logic [12:0] i_plus;
  logic [CW-1:0] x0;
  logic [HW-1:0] y0;
  logic [CW:0]   col;
  logic [7:0]  bcd_rem, bcd_h, bcd_o, bcd_dig;
  logic [15:0] bcd_prod;
  logic [3:0]  bcd_t;
  logic        alu_flag_op, key_skip, cnt_end;

  assign in_acc   = in_i.valid && in_i.ready;
  assign out_free = !out_valid_q || out_o.ready;
  assign in_i.ready = (state_q == S_IDLE);
  assign out_o.valid = out_valid_q;
  assign out_o.data  = out_q;

  assign op     = opcode_e'(word_q[15:12]);
  assign wx     = word_q[11:8];
  assign wn     = word_q[3:0];
  assign nn     = word_q[7:0];
  assign nnn    = word_q[11:0];
  assign pc_n   = pc_q + 12'd2;
  assign pc_s   = pc_q + 12'd4;
  assign i_plus = {1'b0, i_q} + 13'(cnt_q);
  assign vr_val = vr_rvld_q ? vr_rdata_q : 8'h00;
  assign cnt_end = (cnt_q == wx);
  assign alu_flag_op = (wn == ALU_ADD) || (wn == ALU_SUB) || (wn == ALU_SHR) ||
                       (wn == ALU_SBN) || (wn == ALU_SHL);
  assign key_skip = (vx_q[7:4] == 4'h0) &&
                    (((nn == NN_SKP) && keys_q[vx_q[3:0]]) ||
                     ((nn == NN_SKNP) && !keys_q[vx_q[3:0]]));

  // Sprite placement: eight columns from x0, wrapped at the right edge.
  assign x0 = CW'(vx_q % 8'(SCREEN_W));
  assign y0 = HW'(vy_q % 8'(SCREEN_H));
  assign draw_row = HW'((6'(y0) + 6'(cnt_q)) % 6'(SCREEN_H));
  assign fb_old = fb_rvld_q ? fb_rdata_q : '0;
  always_comb begin
    spr_mask = '0;
    col = '0;
    for (int c = 0; c < 8; c++) begin
      col = (CW+1)'(x0) + (CW+1)'(c);
      if (col >= (CW+1)'(SCREEN_W)) col = col - (CW+1)'(SCREEN_W);
      if (ram_rdata_q[7-c]) spr_mask[col[CW-1:0]] = 1'b1;
    end
  end

  // Decimal digits of Vx.
  assign bcd_h    = (vx_q >= 8'd200) ? 8'd2 : ((vx_q >= 8'd100) ? 8'd1 : 8'd0);
  assign bcd_rem  = vx_q - ((vx_q >= 8'd200) ? 8'd200 : ((vx_q >= 8'd100) ? 8'd100 : 8'd0));
  assign bcd_prod = 16'(bcd_rem) * 16'd205;
  assign bcd_t    = 4'(bcd_prod >> 11);
  assign bcd_o    = bcd_rem - 8'(bcd_t) * 8'd10;
  always_comb begin
    case (cnt_q)
      4'd0:    bcd_dig = bcd_h;
      4'd1:    bcd_dig = 8'(bcd_t);
      default: bcd_dig = bcd_o;
    endcase
  end

  // Next state.
  always_comb begin
    state_d = state_q;
    case (state_q)
      S_IDLE: begin
        if (in_acc) begin
          case (in_i.data.action)
            ACT_EXEC:  state_d = S_F1;
            ACT_READ:  state_d = S_RRAM;
            ACT_PIXEL: state_d = S_RPIX;
            default:   state_d = S_DONE;
          endcase
        end
      end
      S_RRAM, S_RPIX, S_RET, S_WF, S_DVF: state_d = S_DONE;
      S_F1: state_d = S_F2;
      S_F2: state_d = S_F3;
      S_F3: state_d = S_X;
      S_X: begin
        state_d = S_DONE;
        case (op)
          OP_SYS:  if (word_q == W_RET && sl_q != 5'd0) state_d = S_RET;
          OP_ALU:  if (alu_flag_op) state_d = S_WF;
          OP_DRW:  state_d = (wn == 4'd0) ? S_DVF : S_DRD;
          OP_MISC: begin
            case (nn)
              F_BCD:   state_d = S_BCD;
              F_STOR:  state_d = S_STR;
              F_LOAD:  state_d = S_LDR;
              default: state_d = S_DONE;
            endcase
          end
          default: state_d = S_DONE;
        endcase
      end
      S_DRD: state_d = S_DWR;
      S_DWR: state_d = (cnt_q + 4'd1 == wn) ? S_DVF : S_DRD;
      S_BCD: if (cnt_q == 4'd2) state_d = S_DONE;
      S_STR: state_d = S_STW;
      S_STW: state_d = cnt_end ? S_DONE : S_STR;
      S_LDR: state_d = S_LDW;
      S_LDW: state_d = cnt_end ? S_DONE : S_LDR;
      S_DONE: if (out_free) state_d = S_IDLE;
      default: state_d = S_IDLE;
    endcase
  end

  // Datapath and memory controls.
  always_comb begin
    pc_d = pc_q; i_d = i_q; sl_d = sl_q; dt_d = dt_q; st_d = st_q;
    vv_d = vv_q; rv_d = rv_q; word_d = word_q; vx_d = vx_q; vy_d = vy_q;
    rd_d = rd_q; cnt_d = cnt_q; wreg_d = wreg_q; hit_d = hit_q; ev_d = ev_q;
    out_valid_d = out_valid_q && !out_o.ready;
    out_d = out_q;
    ram_we = 1'b0; ram_waddr = ram_at(i_plus); ram_wdata = bcd_dig;
    ram_raddr = ram_at(i_plus);
    vr_we = 1'b0; vr_waddr = wx; vr_wdata = 8'h00; vr_raddr = cnt_q;
    stk_we = 1'b0; stk_waddr = sl_q[SW-1:0]; stk_wdata = pc_n;
    stk_raddr = SW'(sl_q - 5'd1);
    fb_we = 1'b0; fb_waddr = draw_row; fb_wdata = fb_old ^ spr_mask;
    fb_raddr = draw_row;
    case (state_q)
      S_IDLE: begin
        ev_d = EV_NONE; rd_d = 8'h00; wreg_d = 4'h0; word_d = 16'h0000;
        ram_raddr = (in_i.data.action == ACT_READ) ?
                    ram_at({1'b0, in_i.data.address}) : ram_at({1'b0, pc_q});
        fb_raddr = HW'(in_i.data.address / 12'(SCREEN_W));
        if (in_acc && in_i.data.action == ACT_WRITE) begin
          ram_we = 1'b1;
          ram_waddr = ram_at({1'b0, in_i.data.address});
          ram_wdata = in_i.data.write_data;
        end
      end
      S_RRAM: rd_d = ram_rdata_q;
      S_RPIX: begin
        rd_d = 8'(({1'b0, addr_q} < 13'(PIXELS)) && fb_rvld_q &&
                  fb_rdata_q[CW'(addr_q % 12'(SCREEN_W))]);
      end
      S_F1: begin
        word_d[15:8] = ram_rdata_q;
        ram_raddr = ram_at({1'b0, pc_q} + 13'd1);
        vr_raddr = ram_rdata_q[3:0];
      end
      S_F2: begin
        word_d[7:0] = ram_rdata_q;
        vx_d = vr_val;
        vr_raddr = ram_rdata_q[7:4];
      end
      S_F3: begin
        vy_d = vr_val;
        vr_raddr = 4'h0;
      end
      S_X: begin
        pc_d = pc_n;
        cnt_d = 4'd0;
        hit_d = 1'b0;
        case (op)
          OP_SYS: begin
            if (word_q == W_CLS) begin
              rv_d = '0;
              ev_d = EV_CLEAR;
            end else if (word_q == W_RET) begin
              if (sl_q == 5'd0) ev_d = EV_STACK;
              else sl_d = sl_q - 5'd1;
            end
          end
          OP_JP: pc_d = nnn;
          OP_CALL: begin
            if (sl_q >= 5'(STACK_DEPTH)) begin
              ev_d = EV_STACK;
            end else begin
              stk_we = 1'b1;
              sl_d = sl_q + 5'd1;
              pc_d = nnn;
            end
          end
          OP_SEI:  if (vx_q == nn) pc_d = pc_s;
          OP_SNEI: if (vx_q != nn) pc_d = pc_s;
          OP_SER:  if (wn == 4'd0 && vx_q == vy_q) pc_d = pc_s;
          OP_SNER: if (wn == 4'd0 && vx_q != vy_q) pc_d = pc_s;
          OP_LDI:  begin vr_we = 1'b1; vr_wdata = nn; end
          OP_ADDI: begin vr_we = 1'b1; vr_wdata = vx_q + nn; end
          OP_ALU: begin
            vr_we = 1'b1;
            case (wn)
              ALU_MOV: vr_wdata = vy_q;
              ALU_OR:  vr_wdata = vx_q | vy_q;
              ALU_AND: vr_wdata = vx_q & vy_q;
              ALU_XOR: vr_wdata = vx_q ^ vy_q;
              ALU_ADD: begin
                vr_wdata = vx_q + vy_q;
                hit_d = ({1'b0, vx_q} + {1'b0, vy_q}) > 9'h0FF;
              end
              ALU_SUB: begin vr_wdata = vx_q - vy_q; hit_d = vx_q >= vy_q; end
              ALU_SHR: begin vr_wdata = vx_q >> 1; hit_d = vx_q[0]; end
              ALU_SBN: begin vr_wdata = vy_q - vx_q; hit_d = vy_q >= vx_q; end
              ALU_SHL: begin vr_wdata = vx_q << 1; hit_d = vx_q[7]; end
              default: vr_we = 1'b0;
            endcase
          end
          OP_LDIX: i_d = nnn;
          OP_JPV0: pc_d = 12'(vr_val) + nnn;
          OP_RND:  begin vr_we = 1'b1; vr_wdata = rnd_q & nn; end
          OP_KEY:  if (key_skip) pc_d = pc_s;
          OP_MISC: begin
            case (nn)
              F_GDT:  begin vr_we = 1'b1; vr_wdata = dt_q; end
              F_WAIT: begin ev_d = EV_WAIT; wreg_d = wx; end
              F_SDT:  dt_d = vx_q;
              F_SST:  st_d = vx_q;
              F_ADDI: i_d = i_q + 12'(vx_q);
              F_FONT: i_d = 12'({vx_q, 2'b00}) + 12'(vx_q);
              default: ;
            endcase
          end
          default: ;
        endcase
      end
      S_RET: pc_d = stk_rdata_q;
      S_WF: begin
        vr_we = 1'b1; vr_waddr = VF_IDX; vr_wdata = 8'(hit_q);
      end
      S_DWR: begin
        fb_we = 1'b1;
        rv_d[draw_row] = 1'b1;
        hit_d = hit_q | (|(fb_old & spr_mask));
        cnt_d = cnt_q + 4'd1;
      end
      S_DVF: begin
        vr_we = 1'b1; vr_waddr = VF_IDX; vr_wdata = 8'(hit_q);
        ev_d = EV_DRAW;
      end
      S_BCD: begin
        ram_we = 1'b1;
        cnt_d = cnt_q + 4'd1;
      end
      S_STW: begin
        ram_we = 1'b1; ram_wdata = vr_val;
        cnt_d = cnt_q + 4'd1;
      end
      S_LDW: begin
        vr_we = 1'b1; vr_waddr = cnt_q; vr_wdata = ram_rdata_q;
        cnt_d = cnt_q + 4'd1;
      end
      S_DONE: begin
        if (out_free) begin
          out_valid_d = 1'b1;
          out_d.event_res     = ev_q;
          out_d.next_pc       = pc_q;
          out_d.executed_word = word_q;
          out_d.read_data     = rd_q;
          out_d.carry_flag    = vf_q;
          out_d.wait_register = wreg_q;
        end
      end
      default: ;
    endcase
    if (vr_we) vv_d[vr_waddr] = 1'b1;
  end

  // VF is shadowed so the result can carry it without a register file read.
  assign vf_d = (vr_we && vr_waddr == VF_IDX) ? vr_wdata : vf_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      pc_q <= PC_RESET; i_q <= '0; sl_q <= '0; dt_q <= '0; st_q <= '0;
      vf_q <= '0; vv_q <= '0; rv_q <= '0; out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      pc_q <= pc_d; i_q <= i_d; sl_q <= sl_d; dt_q <= dt_d; st_q <= st_d;
      vf_q <= vf_d; vv_q <= vv_d; rv_q <= rv_d; out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    word_q <= word_d; vx_q <= vx_d; vy_q <= vy_d; rd_q <= rd_d;
    cnt_q <= cnt_d; wreg_q <= wreg_d; hit_q <= hit_d; ev_q <= ev_d;
    out_q <= out_d;
    if (in_acc) begin
      addr_q <= in_i.data.address;
      keys_q <= in_i.data.key_state;
      rnd_q  <= in_i.data.random_byte;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ram_we) ram_mem[ram_waddr] <= ram_wdata;
    ram_rdata_q <= ram_mem[ram_raddr];
  end

  always_ff @(posedge clk_i) begin
    if (vr_we) vr_mem[vr_waddr] <= vr_wdata;
    vr_rdata_q <= vr_mem[vr_raddr];
    vr_rvld_q  <= vv_q[vr_raddr];
  end

  always_ff @(posedge clk_i) begin
    if (stk_we) stk_mem[stk_waddr] <= stk_wdata;
    stk_rdata_q <= stk_mem[stk_raddr];
  end

  always_ff @(posedge clk_i) begin
    if (fb_we) fb_mem[fb_waddr] <= fb_wdata;
    fb_rdata_q <= fb_mem[fb_raddr];
    fb_rvld_q  <= rv_q[fb_raddr];
  end

  `VMXU_ASSERT_NOW(a_stack_bound, 1'b1, sl_q <= 5'(STACK_DEPTH), "stack level overflow")
  `VMXU_ASSERT_NEXT(a_accept_busy, in_acc, state_q != S_IDLE, "accept did not start work")
  `VMXU_ASSERT_NEXT(a_done_out, state_q == S_DONE && out_free, out_valid_q,
                    "finished result not registered")
  `VMXU_ASSERT_NOW(a_draw_count, state_q == S_DWR, cnt_q < wn, "sprite row past its height")

endmodule
`default_nettype wire
